[design/ahsr_pkg.sv]
// ----------------------------------------------------------------------------
// Accelerometer scale reduction package
// Shared widths, register indexes and reset values of the scale reduction block.
// ----------------------------------------------------------------------------
`default_nettype none

package ahsr_pkg;

    // Default sample width and fraction bits of the scale factor.
    localparam int SAMPLE_WIDTH_DEF    = 16;
    localparam int SCALE_FRAC_BITS_DEF = 24;

    // Fixed widths of the stored scale and of the configuration registers.
    localparam int SCALE_WIDTH   = 32;
    localparam int FACTOR_WIDTH  = 25;
    localparam int THRESH_WIDTH  = 13;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH = FACTOR_WIDTH;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SCALE_UP    = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SCALE_DOWN  = 2'd2;

    // Register reset values.
    localparam logic [THRESH_WIDTH-1:0] THRESH_RST     = 13'd123;
    localparam logic [FACTOR_WIDTH-1:0] SCALE_UP_RST   = 25'd16778893;
    localparam logic [FACTOR_WIDTH-1:0] SCALE_DOWN_RST = 25'd16775540;

endpackage

`default_nettype wire

[design/accel_heuristic_scale_reduction.sv]
// ----------------------------------------------------------------------------
// Accelerometer heuristic scale reduction
// Scales a three-axis sample and adapts the scale toward a one g magnitude.
// ----------------------------------------------------------------------------
// Each input word is one accelerometer sample in Q3.12 g units. The block
// scales every axis by the stored Q8.24 scale, reports the scaled vector and
// the magnitude error floor(sqrt(x*x + y*y + z*z)) - 1 g, and, when the error
// is nonzero and lies strictly inside the threshold band, multiplies the
// scale by the down factor (magnitude above one g) or the up factor
// (magnitude below one g). A sample passes in order through the axis lanes,
// the start of the square root unit, the square root at one root bit per
// cycle, the error step, the scale multiply, and the step that rounds the
// scale and writes the result word; the block then returns to idle, where
// the next sample is taken. The next sample waits for the new scale. The
// result-writing step waits as long as an earlier result word is still held
// and stalled in the output register.
// A finished result sits in an output register, so a new sample is taken
// while the previous result is still waiting downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_heuristic_scale_reduction import ahsr_pkg::*; #(
    parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Sample input channel.
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_accel_x,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_accel_y,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_accel_z,
    // Result output channel.
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]      o_scaled_x,
    output logic signed [SAMPLE_WIDTH-1:0]      o_scaled_y,
    output logic signed [SAMPLE_WIDTH-1:0]      o_scaled_z,
    output logic signed [SAMPLE_WIDTH:0]        o_magnitude_error,
    output logic                                o_scale_adjusted,
    // Configuration write channel.
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [CFG_IDX_WIDTH-1:0]       i_cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]      i_cfg_data
);

    // Sequencer state codes.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PIPE  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_SQRT  = 3'd3;
    localparam logic [2:0] S_UPD   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    localparam int EW = SAMPLE_WIDTH + 1;
    // The error and the threshold are compared at a width that holds both signed.
    localparam int TW = (EW > THRESH_WIDTH + 1) ? EW : THRESH_WIDTH + 1;
    localparam int PW = SCALE_WIDTH + FACTOR_WIDTH;
    localparam logic signed [EW-1:0] ONE_G    = EW'(1) << (SAMPLE_WIDTH - 4);
    localparam logic [SCALE_WIDTH-1:0] SCALE_RST = SCALE_WIDTH'(1) << SCALE_FRAC_BITS;
    localparam logic [PW-1:0] HALF      = PW'(1) << (SCALE_FRAC_BITS - 1);
    localparam logic [PW-1:0] SCALE_MAX = PW'({SCALE_WIDTH{1'b1}});

    logic [2:0]                     r_state;
    logic [2:0]                     n_state;
    logic [1:0]                     r_cnt;
    logic                           w_in_fire;
    logic                           w_out_free;

    logic [THRESH_WIDTH-1:0]        r_threshold;
    logic [FACTOR_WIDTH-1:0]        r_up_factor;
    logic [FACTOR_WIDTH-1:0]        r_down_factor;
    logic [SCALE_WIDTH-1:0]         r_scale;
    logic [SCALE_WIDTH-1:0]         n_scale;

    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic signed [SAMPLE_WIDTH-1:0] r_y;
    logic signed [SAMPLE_WIDTH-1:0] r_z;
    logic signed [SAMPLE_WIDTH-1:0] w_val_x;
    logic signed [SAMPLE_WIDTH-1:0] w_val_y;
    logic signed [SAMPLE_WIDTH-1:0] w_val_z;
    logic [2*SAMPLE_WIDTH-2:0]      w_sq_x;
    logic [2*SAMPLE_WIDTH-2:0]      w_sq_y;
    logic [2*SAMPLE_WIDTH-2:0]      w_sq_z;

    logic                           w_sqrt_start;
    logic                           w_sqrt_done;
    logic [SAMPLE_WIDTH-1:0]        w_root;

    logic signed [EW-1:0]           r_err;
    logic signed [TW-1:0]           w_err_ext;
    logic signed [TW-1:0]           w_thr_ext;
    logic                           r_apply;
    logic [PW-1:0]                  r_sprod;
    logic [PW-1:0]                  w_sq_round;

    logic                           r_out_valid;

    // The three axis lanes run side by side on the captured sample.
    ahsr_lane #(
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_lane_x (
        .i_clk    (i_clk),
        .i_sample (r_x),
        .i_scale  (r_scale),
        .o_value  (w_val_x),
        .o_square (w_sq_x)
    );

    ahsr_lane #(
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_lane_y (
        .i_clk    (i_clk),
        .i_sample (r_y),
        .i_scale  (r_scale),
        .o_value  (w_val_y),
        .o_square (w_sq_y)
    );

    ahsr_lane #(
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_lane_z (
        .i_clk    (i_clk),
        .i_sample (r_z),
        .i_scale  (r_scale),
        .o_value  (w_val_z),
        .o_square (w_sq_z)
    );

    // The merge stage sums the lane squares and takes the square root.
    ahsr_merge #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_square_x (w_sq_x),
        .i_square_y (w_sq_y),
        .i_square_z (w_sq_z),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    assign o_in_stall   = (r_state != S_IDLE);
    assign w_in_fire    = i_in_valid && !o_in_stall;
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_sqrt_start = (r_state == S_START);
    assign o_cfg_ready  = 1'b1;

    // Sequencer: lanes, square root, scale multiply, then rounding and output.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_fire) n_state = S_PIPE;
            S_PIPE:  if (r_cnt == 2'd2) n_state = S_START;
            S_START: n_state = S_SQRT;
            S_SQRT:  if (w_sqrt_done) n_state = S_UPD;
            S_UPD:   n_state = S_FIN;
            S_FIN:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_PIPE) begin
                r_cnt <= r_cnt + 2'd1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // Configuration registers. Writes to an unknown index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= THRESH_RST;
            r_up_factor   <= SCALE_UP_RST;
            r_down_factor <= SCALE_DOWN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD:  r_threshold   <= i_cfg_data[THRESH_WIDTH-1:0];
                CFG_SCALE_UP:   r_up_factor   <= i_cfg_data;
                CFG_SCALE_DOWN: r_down_factor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sample capture; the lanes read these registers every cycle.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_x <= i_accel_x;
            r_y <= i_accel_y;
            r_z <= i_accel_z;
        end
    end

    // The band test is strict on both sides, and a zero error never adapts.
    assign w_err_ext = TW'(r_err);
    assign w_thr_ext = $signed({{(TW - THRESH_WIDTH){1'b0}}, r_threshold});

    always_ff @(posedge i_clk) begin
        if (r_state == S_SQRT && w_sqrt_done) begin
            r_err <= $signed({1'b0, w_root}) - ONE_G;
        end
        if (r_state == S_UPD) begin
            r_apply <= (w_err_ext > -w_thr_ext) && (w_err_ext < w_thr_ext)
                       && (r_err != '0);
            // A negative error means the vector is short of one g.
            if (r_err[EW-1]) begin
                r_sprod <= PW'(r_scale) * PW'(r_up_factor);
            end else begin
                r_sprod <= PW'(r_scale) * PW'(r_down_factor);
            end
        end
    end

    // New scale: round to nearest at the fraction point, clamp to 32 bits.
    always_comb begin
        w_sq_round = (r_sprod + HALF) >> SCALE_FRAC_BITS;
        n_scale    = r_scale;
        if (r_apply) begin
            if (w_sq_round > SCALE_MAX) begin
                n_scale = SCALE_MAX[SCALE_WIDTH-1:0];
            end else begin
                n_scale = w_sq_round[SCALE_WIDTH-1:0];
            end
        end
    end

    // The scale changes only in the cycle its result word is written out, so
    // the lane values still hold the old scale's products at that edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= SCALE_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_FIN && w_out_free) begin
                r_scale     <= n_scale;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && w_out_free) begin
            o_scaled_x        <= w_val_x;
            o_scaled_y        <= w_val_y;
            o_scaled_z        <= w_val_z;
            o_magnitude_error <= r_err;
            o_scale_adjusted  <= (n_scale != r_scale);
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[design/ahsr_lane.sv]
// ----------------------------------------------------------------------------
// Scale reduction axis lane
// Multiplies one axis by the scale, rounds and saturates it, and squares it.
// ----------------------------------------------------------------------------
`default_nettype none

module ahsr_lane import ahsr_pkg::*; #(
    parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic [SCALE_WIDTH-1:0]         i_scale,
    output logic signed [SAMPLE_WIDTH-1:0]      o_value,
    output logic [2*SAMPLE_WIDTH-2:0]           o_square
);

    localparam int PW  = SAMPLE_WIDTH + SCALE_WIDTH + 1;
    localparam int SQW = 2 * SAMPLE_WIDTH;
    localparam logic signed [PW-1:0] HALF = PW'(1) << (SCALE_FRAC_BITS - 1);
    localparam logic signed [PW-1:0] HI   = (PW'(1) << (SAMPLE_WIDTH - 1)) - PW'(1);
    localparam logic signed [PW-1:0] LO   = ~HI;

    logic signed [PW-1:0]             r_prod;
    logic signed [PW-1:0]             w_round;
    logic signed [SAMPLE_WIDTH-1:0]   w_sat;
    logic signed [SAMPLE_WIDTH-1:0]   r_value;
    logic signed [SQW-1:0]            w_sq;
    logic [2*SAMPLE_WIDTH-2:0]        r_square;

    // Round to nearest with ties upward, then clamp to the sample range.
    always_comb begin
        w_round = (r_prod + HALF) >>> SCALE_FRAC_BITS;
        if (w_round > HI) begin
            w_sat = HI[SAMPLE_WIDTH-1:0];
        end else if (w_round < LO) begin
            w_sat = LO[SAMPLE_WIDTH-1:0];
        end else begin
            w_sat = w_round[SAMPLE_WIDTH-1:0];
        end
    end

    assign w_sq = SQW'(r_value) * SQW'(r_value);

    always_ff @(posedge i_clk) begin
        r_prod   <= PW'(i_sample) * PW'($signed({1'b0, i_scale}));
        r_value  <= w_sat;
        r_square <= w_sq[2*SAMPLE_WIDTH-2:0];
    end

    assign o_value  = r_value;
    assign o_square = r_square;

endmodule

`default_nettype wire

[design/ahsr_merge.sv]
// ----------------------------------------------------------------------------
// Scale reduction magnitude merge
// Sums the lane squares and takes the floor square root, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ahsr_merge import ahsr_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [2*SAMPLE_WIDTH-2:0]    i_square_x,
    input  wire logic [2*SAMPLE_WIDTH-2:0]    i_square_y,
    input  wire logic [2*SAMPLE_WIDTH-2:0]    i_square_z,
    output logic                              o_done,
    output logic [SAMPLE_WIDTH-1:0]           o_root
);

    localparam int NW = 2 * SAMPLE_WIDTH;
    localparam int CW = $clog2(SAMPLE_WIDTH);
    localparam logic [NW-1:0] BIT_INIT = NW'(1) << (NW - 2);

    logic [NW-1:0] w_sum;
    logic [NW-1:0] w_trial;
    logic          w_ge;
    logic [NW-1:0] r_n;
    logic [NW-1:0] r_root;
    logic [NW-1:0] r_bit;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    // Three squares stay below four times the largest square, so no carry is lost.
    assign w_sum   = {1'b0, i_square_x} + {1'b0, i_square_y} + {1'b0, i_square_z};
    assign w_trial = r_root + r_bit;
    assign w_ge    = (r_n >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(SAMPLE_WIDTH - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(SAMPLE_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= w_sum;
            r_root <= '0;
            r_bit  <= BIT_INIT;
        end else if (r_busy) begin
            if (w_ge) begin
                r_n    <= r_n - w_trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root[SAMPLE_WIDTH-1:0];

endmodule

`default_nettype wire
